### rtl/grid_balanced_match_interleaver_macros.svh
// Assertion macros for the grid balanced match interleaver checker
`ifndef GRID_BALANCED_MATCH_INTERLEAVER_MACROS_SVH
`define GRID_BALANCED_MATCH_INTERLEAVER_MACROS_SVH

// Clocked property, off while reset is asserted
`define GBMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property, checked during reset too
`define GBMI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/gbmi_pkg.sv
// Shared constants, types and functions of the grid balanced match interleaver
package gbmi_pkg;

  localparam int unsigned MAX_MATCHES  = 4096;
  localparam int unsigned GRID_SIDE    = 3;
  localparam int unsigned NUM_CELLS    = 2 * GRID_SIDE * GRID_SIDE;
  localparam int unsigned ADDR_W       = $clog2(MAX_MATCHES);
  localparam int unsigned CNT_W        = $clog2(MAX_MATCHES + 1);
  localparam int unsigned CELL_W       = $clog2(NUM_CELLS);
  localparam int unsigned CFG_W        = 15;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned COORD_W      = 14;
  localparam int unsigned IDX_W        = 16;
  localparam int unsigned SIDE_W       = 15;
  localparam int unsigned SUM_W        = CFG_W + 1;
  localparam int unsigned THR_W        = SIDE_W + 3;
  localparam int unsigned RECIP_SHIFT  = 17;
  localparam int unsigned RECIP        = (2 ** RECIP_SHIFT + GRID_SIDE - 1) / GRID_SIDE;
  localparam int unsigned RECIP_W      = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W       = SUM_W + RECIP_W;
  localparam int unsigned RESET_WIDTH  = 1920;
  localparam int unsigned RESET_HEIGHT = 1080;
  localparam int unsigned SIDE_RST_W   = (RESET_WIDTH + GRID_SIDE - 1) / GRID_SIDE;
  localparam int unsigned SIDE_RST_H   = (RESET_HEIGHT + GRID_SIDE - 1) / GRID_SIDE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_WIDTH   = 3'd0,
    CFG_LEFT_HEIGHT  = 3'd1,
    CFG_RIGHT_WIDTH  = 3'd2,
    CFG_RIGHT_HEIGHT = 3'd3
  } cfg_reg_e;

  typedef logic [SIDE_W-1:0] side_t;

  typedef struct packed {
    logic [CELL_W-1:0] left_cell;
    logic [CELL_W-1:0] right_cell;
  } cell_pair_t;

  function automatic side_t cell_side(logic [CFG_W-1:0] size);
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    side_t             s;
    sum  = SUM_W'(size) + SUM_W'(GRID_SIDE - 1);
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    s    = prod[RECIP_SHIFT +: SIDE_W];
    if (s == '0) begin
      s = SIDE_W'(1);
    end
    return s;
  endfunction

  function automatic logic [CELL_W-1:0] axis_cell(logic [COORD_W-1:0] coord, side_t side);
    logic [THR_W-1:0]  thr;
    logic [CELL_W-1:0] c;
    thr = '0;
    c   = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      thr = thr + THR_W'(side);
      if (THR_W'(coord) >= thr) begin
        c = CELL_W'(k);
      end
    end
    return c;
  endfunction

endpackage

### rtl/gbmi_ram.sv
// Generic single-write, single-read RAM with registered read data
module gbmi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gbmi_cell_map.sv
// Maps the coordinates of a match to its left and right grid cells
module gbmi_cell_map (
  input  logic [gbmi_pkg::COORD_W-1:0] left_x_i,
  input  logic [gbmi_pkg::COORD_W-1:0] left_y_i,
  input  logic [gbmi_pkg::COORD_W-1:0] right_x_i,
  input  logic [gbmi_pkg::COORD_W-1:0] right_y_i,
  input  gbmi_pkg::side_t              left_side_w_i,
  input  gbmi_pkg::side_t              left_side_h_i,
  input  gbmi_pkg::side_t              right_side_w_i,
  input  gbmi_pkg::side_t              right_side_h_i,
  output gbmi_pkg::cell_pair_t         cells_o
);

  logic [gbmi_pkg::CELL_W-1:0] lcol, lrow, rcol, rrow;

  always_comb begin
    lcol = gbmi_pkg::axis_cell(left_x_i, left_side_w_i);
    lrow = gbmi_pkg::axis_cell(left_y_i, left_side_h_i);
    rcol = gbmi_pkg::axis_cell(right_x_i, right_side_w_i);
    rrow = gbmi_pkg::axis_cell(right_y_i, right_side_h_i);
    cells_o.left_cell  = lcol + lrow * gbmi_pkg::CELL_W'(gbmi_pkg::GRID_SIDE);
    cells_o.right_cell = gbmi_pkg::CELL_W'(gbmi_pkg::GRID_SIDE * gbmi_pkg::GRID_SIDE)
                         + rcol + rrow * gbmi_pkg::CELL_W'(gbmi_pkg::GRID_SIDE);
  end

endmodule

### rtl/grid_balanced_match_interleaver.sv
// Load: an item passes through the states MAP, RDL, RDR and WR. A drain scans cell by cell in
// SCAN; on a match it walks the cell's link list in WALK and LINK, fetches the entry in FETCH
// and scans on in SCAN for the next match before it gives the result.
// Throughput: one item at a time through one shared count compare and one link walk;
// in_ready_o is low while an item is at work or a result waits.
// Reset: asynchronous, active low; clears counts, cursors and flags and sets the
// cell sides for 1920x1080 images; the match and link memories are not cleared.
module grid_balanced_match_interleaver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gbmi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbmi_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [gbmi_pkg::IDX_W-1:0]     left_index_i,
  input  logic [gbmi_pkg::IDX_W-1:0]     right_index_i,
  input  logic [gbmi_pkg::COORD_W-1:0]   left_x_i,
  input  logic [gbmi_pkg::COORD_W-1:0]   left_y_i,
  input  logic [gbmi_pkg::COORD_W-1:0]   right_x_i,
  input  logic [gbmi_pkg::COORD_W-1:0]   right_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gbmi_pkg::IDX_W-1:0]     out_left_index_o,
  output logic [gbmi_pkg::IDX_W-1:0]     out_right_index_o,
  output logic                           valid_res_o,
  output logic                           last_o,
  output logic                           overflow_o
);

  localparam int unsigned NC = gbmi_pkg::NUM_CELLS;
  localparam int unsigned AW = gbmi_pkg::ADDR_W;
  localparam int unsigned CW = gbmi_pkg::CNT_W;
  localparam int unsigned LW = gbmi_pkg::CELL_W;
  localparam int unsigned EW = 2 * gbmi_pkg::IDX_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MAP   = 9'b000000010,
    ST_RDL   = 9'b000000100,
    ST_RDR   = 9'b000001000,
    ST_WR    = 9'b000010000,
    ST_SCAN  = 9'b000100000,
    ST_WALK  = 9'b001000000,
    ST_LINK  = 9'b010000000,
    ST_FETCH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  gbmi_pkg::side_t side_q [4];
  gbmi_pkg::side_t side_d [4];

  logic [gbmi_pkg::IDX_W-1:0]   li_q, li_d, ri_q, ri_d;
  logic [gbmi_pkg::COORD_W-1:0] lx_q, lx_d, ly_q, ly_d, rx_q, rx_d, ry_q, ry_d;

  logic [LW-1:0] lc_q, lc_d, rc_q, rc_d, dst_q, dst_d;
  logic [CW-1:0] cntl_q, cntl_d;

  logic [CW-1:0] count_q    [NC];
  logic [CW-1:0] count_d    [NC];
  logic [CW-1:0] cur_rank_q [NC];
  logic [CW-1:0] cur_rank_d [NC];
  logic [AW-1:0] cur_ptr_q  [NC];
  logic [AW-1:0] cur_ptr_d  [NC];
  logic [AW-1:0] tail_q     [NC];
  logic [AW-1:0] tail_d     [NC];

  logic [CW-1:0] total_q, total_d, top_q, top_d;
  logic [CW-1:0] drain_rank_q, drain_rank_d, scan_rank_q, scan_rank_d;
  logic [CW-1:0] hit_rank_q, hit_rank_d, nxt_rank_q, nxt_rank_d;
  logic [LW-1:0] drain_cell_q, drain_cell_d, scan_cell_q, scan_cell_d;
  logic [LW-1:0] hit_cell_q, hit_cell_d, nxt_cell_q, nxt_cell_d;
  logic          ovf_q, ovf_d, second_q, second_d;
  logic [EW-1:0] entry_q, entry_d;

  logic                       out_valid_q, out_valid_d;
  logic [gbmi_pkg::IDX_W-1:0] out_li_q, out_li_d, out_ri_q, out_ri_d;
  logic                       out_vr_q, out_vr_d, out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  gbmi_pkg::cell_pair_t cells;
  logic [LW-1:0]        cell_sel;
  logic [CW-1:0]        cnt_sel, cur_rank_sel, cnt_inc;
  logic [AW-1:0]        cur_ptr_sel, tail_sel;
  logic                 accept;
  logic                 store_we, link_we;
  logic [EW-1:0]        store_rdata;
  logic [AW-1:0]        link_rdata;
  logic [LW-1:0]        hit_next_cell;
  logic [CW-1:0]        hit_next_rank;

  gbmi_cell_map u_cell_map (
    .left_x_i       (lx_q),
    .left_y_i       (ly_q),
    .right_x_i      (rx_q),
    .right_y_i      (ry_q),
    .left_side_w_i  (side_q[0]),
    .left_side_h_i  (side_q[1]),
    .right_side_w_i (side_q[2]),
    .right_side_h_i (side_q[3]),
    .cells_o        (cells)
  );

  gbmi_ram #(.WIDTH(EW), .DEPTH(gbmi_pkg::MAX_MATCHES)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i ({li_q, ri_q}),
    .raddr_i (cur_ptr_sel),
    .rdata_o (store_rdata)
  );

  gbmi_ram #(.WIDTH(AW), .DEPTH(gbmi_pkg::MAX_MATCHES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (tail_sel),
    .wdata_i (total_q[AW-1:0]),
    .raddr_i (cur_ptr_sel),
    .rdata_o (link_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    case (state_q)
      ST_RDL:                     cell_sel = lc_q;
      ST_RDR:                     cell_sel = rc_q;
      ST_WR:                      cell_sel = dst_q;
      ST_WALK, ST_LINK, ST_FETCH: cell_sel = hit_cell_q;
      default:                    cell_sel = scan_cell_q;
    endcase
  end

  assign cnt_sel       = count_q[cell_sel];
  assign cur_rank_sel  = cur_rank_q[cell_sel];
  assign cur_ptr_sel   = cur_ptr_q[cell_sel];
  assign tail_sel      = tail_q[cell_sel];
  assign cnt_inc       = cnt_sel + CW'(1);
  assign hit_next_cell = (hit_cell_q == LW'(NC - 1)) ? '0 : hit_cell_q + LW'(1);
  assign hit_next_rank = (hit_cell_q == LW'(NC - 1)) ? hit_rank_q + CW'(1) : hit_rank_q;

  always_comb begin
    state_d      = state_q;
    side_d       = side_q;
    li_d         = li_q;
    ri_d         = ri_q;
    lx_d         = lx_q;
    ly_d         = ly_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    lc_d         = lc_q;
    rc_d         = rc_q;
    dst_d        = dst_q;
    cntl_d       = cntl_q;
    count_d      = count_q;
    cur_rank_d   = cur_rank_q;
    cur_ptr_d    = cur_ptr_q;
    tail_d       = tail_q;
    total_d      = total_q;
    top_d        = top_q;
    drain_rank_d = drain_rank_q;
    drain_cell_d = drain_cell_q;
    scan_rank_d  = scan_rank_q;
    scan_cell_d  = scan_cell_q;
    hit_rank_d   = hit_rank_q;
    hit_cell_d   = hit_cell_q;
    nxt_rank_d   = nxt_rank_q;
    nxt_cell_d   = nxt_cell_q;
    ovf_d        = ovf_q;
    second_d     = second_q;
    entry_d      = entry_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_li_d     = out_li_q;
    out_ri_d     = out_ri_q;
    out_vr_d     = out_vr_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    store_we     = 1'b0;
    link_we      = 1'b0;

    if (cfg_we_i) begin
      case (gbmi_pkg::cfg_reg_e'(cfg_idx_i))
        gbmi_pkg::CFG_LEFT_WIDTH:   side_d[0] = gbmi_pkg::cell_side(cfg_data_i);
        gbmi_pkg::CFG_LEFT_HEIGHT:  side_d[1] = gbmi_pkg::cell_side(cfg_data_i);
        gbmi_pkg::CFG_RIGHT_WIDTH:  side_d[2] = gbmi_pkg::cell_side(cfg_data_i);
        gbmi_pkg::CFG_RIGHT_HEIGHT: side_d[3] = gbmi_pkg::cell_side(cfg_data_i);
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          li_d = left_index_i;
          ri_d = right_index_i;
          lx_d = left_x_i;
          ly_d = left_y_i;
          rx_d = right_x_i;
          ry_d = right_y_i;
          if (!func_i) begin
            if (total_q == CW'(gbmi_pkg::MAX_MATCHES)) begin
              ovf_d = 1'b1;
            end else begin
              state_d = ST_MAP;
            end
          end else begin
            scan_rank_d = drain_rank_q;
            scan_cell_d = drain_cell_q;
            second_d    = 1'b0;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_MAP: begin
        lc_d    = cells.left_cell;
        rc_d    = cells.right_cell;
        state_d = ST_RDL;
      end
      ST_RDL: begin
        cntl_d  = cnt_sel;
        state_d = ST_RDR;
      end
      ST_RDR: begin
        dst_d   = (cntl_q > cnt_sel) ? rc_q : lc_q;
        state_d = ST_WR;
      end
      ST_WR: begin
        store_we        = 1'b1;
        link_we         = (cnt_sel != '0);
        tail_d[dst_q]   = total_q[AW-1:0];
        if (cur_rank_sel == cnt_sel) begin
          cur_ptr_d[dst_q] = total_q[AW-1:0];
        end
        count_d[dst_q]  = cnt_inc;
        if (cnt_inc > top_q) begin
          top_d = cnt_inc;
        end
        total_d = total_q + CW'(1);
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_rank_q >= top_q) begin
          out_valid_d = 1'b1;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
          if (!second_q) begin
            out_li_d   = '0;
            out_ri_d   = '0;
            out_vr_d   = 1'b0;
            out_last_d = 1'b0;
          end else begin
            out_li_d     = entry_q[EW-1 -: gbmi_pkg::IDX_W];
            out_ri_d     = entry_q[gbmi_pkg::IDX_W-1:0];
            out_vr_d     = 1'b1;
            out_last_d   = 1'b1;
            for (int i = 0; i < NC; i++) begin
              count_d[i]    = '0;
              cur_rank_d[i] = '0;
            end
            total_d      = '0;
            top_d        = '0;
            drain_rank_d = '0;
            drain_cell_d = '0;
            ovf_d        = 1'b0;
          end
        end else if (cnt_sel > scan_rank_q) begin
          if (!second_q) begin
            hit_cell_d = scan_cell_q;
            hit_rank_d = scan_rank_q;
            state_d    = ST_WALK;
          end else begin
            drain_rank_d = nxt_rank_q;
            drain_cell_d = nxt_cell_q;
            out_valid_d  = 1'b1;
            out_li_d     = entry_q[EW-1 -: gbmi_pkg::IDX_W];
            out_ri_d     = entry_q[gbmi_pkg::IDX_W-1:0];
            out_vr_d     = 1'b1;
            out_last_d   = 1'b0;
            out_ovf_d    = ovf_q;
            state_d      = ST_IDLE;
          end
        end else if (scan_cell_q == LW'(NC - 1)) begin
          scan_cell_d = '0;
          scan_rank_d = scan_rank_q + CW'(1);
        end else begin
          scan_cell_d = scan_cell_q + LW'(1);
        end
      end
      ST_WALK: begin
        state_d = (cur_rank_sel == hit_rank_q) ? ST_FETCH : ST_LINK;
      end
      ST_LINK: begin
        cur_ptr_d[hit_cell_q]  = link_rdata;
        cur_rank_d[hit_cell_q] = cur_rank_sel + CW'(1);
        state_d                = ST_WALK;
      end
      ST_FETCH: begin
        entry_d     = store_rdata;
        nxt_rank_d  = hit_next_rank;
        nxt_cell_d  = hit_next_cell;
        scan_rank_d = hit_next_rank;
        scan_cell_d = hit_next_cell;
        second_d    = 1'b1;
        state_d     = ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      side_q[0]    <= gbmi_pkg::SIDE_W'(gbmi_pkg::SIDE_RST_W);
      side_q[1]    <= gbmi_pkg::SIDE_W'(gbmi_pkg::SIDE_RST_H);
      side_q[2]    <= gbmi_pkg::SIDE_W'(gbmi_pkg::SIDE_RST_W);
      side_q[3]    <= gbmi_pkg::SIDE_W'(gbmi_pkg::SIDE_RST_H);
      for (int i = 0; i < NC; i++) begin
        count_q[i]    <= '0;
        cur_rank_q[i] <= '0;
      end
      total_q      <= '0;
      top_q        <= '0;
      drain_rank_q <= '0;
      drain_cell_q <= '0;
      scan_rank_q  <= '0;
      scan_cell_q  <= '0;
      ovf_q        <= 1'b0;
      second_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      side_q       <= side_d;
      count_q      <= count_d;
      cur_rank_q   <= cur_rank_d;
      total_q      <= total_d;
      top_q        <= top_d;
      drain_rank_q <= drain_rank_d;
      drain_cell_q <= drain_cell_d;
      scan_rank_q  <= scan_rank_d;
      scan_cell_q  <= scan_cell_d;
      ovf_q        <= ovf_d;
      second_q     <= second_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    li_q       <= li_d;
    ri_q       <= ri_d;
    lx_q       <= lx_d;
    ly_q       <= ly_d;
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    lc_q       <= lc_d;
    rc_q       <= rc_d;
    dst_q      <= dst_d;
    cntl_q     <= cntl_d;
    cur_ptr_q  <= cur_ptr_d;
    tail_q     <= tail_d;
    hit_rank_q <= hit_rank_d;
    hit_cell_q <= hit_cell_d;
    nxt_rank_q <= nxt_rank_d;
    nxt_cell_q <= nxt_cell_d;
    entry_q    <= entry_d;
    out_li_q   <= out_li_d;
    out_ri_q   <= out_ri_d;
    out_vr_q   <= out_vr_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_left_index_o  = out_li_q;
  assign out_right_index_o = out_ri_q;
  assign valid_res_o       = out_vr_q;
  assign last_o            = out_last_q;
  assign overflow_o        = out_ovf_q;

endmodule

### rtl/gbmi_checker.sv
// Port-level assertions for the grid balanced match interleaver, bound to the top level
`include "grid_balanced_match_interleaver_macros.svh"

module gbmi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [gbmi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [gbmi_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           func_i,
  input logic [gbmi_pkg::IDX_W-1:0]     left_index_i,
  input logic [gbmi_pkg::IDX_W-1:0]     right_index_i,
  input logic [gbmi_pkg::COORD_W-1:0]   left_x_i,
  input logic [gbmi_pkg::COORD_W-1:0]   left_y_i,
  input logic [gbmi_pkg::COORD_W-1:0]   right_x_i,
  input logic [gbmi_pkg::COORD_W-1:0]   right_y_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [gbmi_pkg::IDX_W-1:0]     out_left_index_o,
  input logic [gbmi_pkg::IDX_W-1:0]     out_right_index_o,
  input logic                           valid_res_o,
  input logic                           last_o,
  input logic                           overflow_o
);

  `GBMI_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_left_index_o) && $stable(out_right_index_o) && $stable(last_o) && $stable(overflow_o), "stalled result changed")

  `GBMI_ASSERT(a_empty_result, out_valid_o && !valid_res_o |-> !last_o && out_left_index_o == '0 && out_right_index_o == '0, "empty result carries a match")

  `GBMI_ASSERT_ALWAYS(a_busy_when_pending, out_valid_o |-> !in_ready_o, "item taken while result pending")

  `GBMI_ASSERT(a_load_no_result, in_valid_i && in_ready_o && !func_i |=> !out_valid_o, "load produced a result")

endmodule

bind grid_balanced_match_interleaver gbmi_checker u_gbmi_checker (.*);
